/* rtl/tunhp_pkg.sv */
// Shared types and constants for the tunnel header parser.
`default_nettype none
package tunhp_pkg;

  // Beat widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned CAP_W    = 64;
  localparam int unsigned CNTDN_W  = 9;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTH_TYPE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_TYPE = 1'd1;

  // Configuration reset values
  localparam logic [BYTE_W-1:0] AUTH_TYPE_RST   = 8'd1;
  localparam logic [BYTE_W-1:0] ORIGIN_TYPE_RST = 8'd0;

  // Summary status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TRUNC    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADCONF  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERSIZE = 3'd4;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Header field lengths (bytes still to come)
  localparam logic [CNTDN_W-1:0] NONCE_BYTES   = 9'd8;
  localparam logic [CNTDN_W-1:0] ORIGIN_REMAIN = 9'd6;

  // Result queue
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = 2;
  localparam int unsigned QCNT_W  = 3;
  localparam logic [QCNT_W-1:0] QFULL_FOR_TWO = 3'd3;

  typedef enum logic [3:0] {
    PH_HEAD    = 4'd0,
    PH_IDLEN   = 4'd1,
    PH_AULEN   = 4'd2,
    PH_SKIP    = 4'd3,
    PH_NONCE   = 4'd4,
    PH_CONFIRM = 4'd5,
    PH_ORIGIN  = 4'd6,
    PH_PAYLOAD = 4'd7,
    PH_DROP    = 4'd8
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_datagram;
  } in_beat_t;

  typedef struct packed {
    logic                item_kind;
    logic [BYTE_W-1:0]   payload_byte;
    logic [STATUS_W-1:0] status;
    logic                nonce_present;
    logic [CAP_W-1:0]    nonce_value;
    logic                origin_present;
    logic [CAP_W-1:0]    origin_raw;
    logic [LEN_W-1:0]    payload_length;
    logic                last_of_run;
  } out_beat_t;

endpackage
`default_nettype wire

/* rtl/tunnel_header_parser_core.sv */
// Top level of the tunnel header parser: header walk, capture and result queue.
`default_nettype none
// Takes one datagram byte per beat and parses leading tunnel headers
// (authentication with skipped identity/authenticator, 8-byte nonce and a
// zero confirmation byte; origin indication as 8 raw bytes), then forwards the
// rest as payload beats. The last byte of a datagram adds a summary beat with
// status, captures and payload length. Input beats are taken unless stalled:
// the parse state updates in the same cycle the byte is accepted and results
// go into a four-entry queue. A byte yields zero, one or two result beats;
// input stalls only while the queue has fewer than two free entries, so with
// the output draining one beat per cycle the block runs at one byte per clock
// apart from summary-beat stalls. Type codes come from two configuration
// registers, written by the user only while the block is idle; not enforced.
module tunnel_header_parser_core #(
  parameter int unsigned MAX_DATAGRAM = 65507
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // Input byte channel
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire tunhp_pkg::in_beat_t          in_data,
  // Result channel
  output logic                              out_valid,
  input  wire                               out_stall,
  output tunhp_pkg::out_beat_t              out_data,
  // Configuration writes
  input  wire                               cfg_we,
  input  wire [tunhp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [tunhp_pkg::BYTE_W-1:0]       cfg_data
);
  import tunhp_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_DATAGRAM + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DATAGRAM);

  // Configuration registers
  logic [BYTE_W-1:0] auth_type_r, origin_type_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auth_type_r   <= AUTH_TYPE_RST;
      origin_type_r <= ORIGIN_TYPE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AUTH_TYPE:   auth_type_r   <= cfg_data;
        CFG_ORIGIN_TYPE: origin_type_r <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Parse state
  phase_t              phase_r, phase_nxt;
  logic                held_zero_r, held_zero_nxt;
  logic [CNTDN_W-1:0]  cntdn_r, cntdn_nxt;
  logic [BYTE_W-1:0]   idlen_r, idlen_nxt;
  logic [CAP_W-1:0]    nonce_r, nonce_nxt;
  logic [CAP_W-1:0]    origin_r, origin_nxt;
  logic                nonce_seen_r, nonce_seen_nxt;
  logic                origin_seen_r, origin_seen_nxt;
  logic [STATUS_W-1:0] err_r, err_nxt;
  logic [CNT_W-1:0]    pcnt_r, pcnt_nxt;
  logic [CNT_W-1:0]    tcnt_r, tcnt_nxt;

  // Result queue
  out_beat_t           q_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   qcnt_r;

  logic                accept, pop;
  logic [BYTE_W-1:0]   b;
  logic                last;
  logic                oversize;
  phase_t              eff_phase;
  logic                emit_payload;
  logic                fail;
  logic [STATUS_W-1:0] fail_code;
  logic [CNTDN_W-1:0]  cntdn_dec;
  logic [CNTDN_W-1:0]  len_sum;
  out_beat_t           pay_beat, sum_beat;

  assign in_stall  = (qcnt_r >= QFULL_FOR_TWO);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (qcnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = q_r[rd_ptr_r];

  assign b         = in_data.data_byte;
  assign last      = in_data.end_of_datagram;
  assign oversize  = (tcnt_r >= MAX_CNT);
  assign eff_phase = oversize ? PH_DROP : phase_r;
  assign cntdn_dec = cntdn_r - 1'b1;
  assign len_sum   = CNTDN_W'(idlen_r) + CNTDN_W'(b);

  // Next parse state for the accepted byte
  always_comb begin
    phase_nxt       = phase_r;
    held_zero_nxt   = held_zero_r;
    cntdn_nxt       = cntdn_r;
    idlen_nxt       = idlen_r;
    nonce_nxt       = nonce_r;
    origin_nxt      = origin_r;
    nonce_seen_nxt  = nonce_seen_r;
    origin_seen_nxt = origin_seen_r;
    pcnt_nxt        = pcnt_r;
    tcnt_nxt        = tcnt_r;
    fail            = 1'b0;
    fail_code       = ST_OK;

    if (oversize) begin
      fail      = 1'b1;
      fail_code = ST_OVERSIZE;
    end else begin
      tcnt_nxt = tcnt_r + 1'b1;
    end

    unique case (eff_phase)
      PH_HEAD: begin
        if (!held_zero_r) begin
          if (b == '0 && !last) begin
            held_zero_nxt = 1'b1;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end else begin
          held_zero_nxt = 1'b0;
          if (b == auth_type_r) begin
            phase_nxt = PH_IDLEN;
            if (last) begin
              fail      = 1'b1;
              fail_code = ST_TRUNC;
            end
          end else if (b == origin_type_r) begin
            origin_nxt = CAP_W'(b);
            cntdn_nxt  = ORIGIN_REMAIN;
            phase_nxt  = PH_ORIGIN;
            if (last) begin
              fail      = 1'b1;
              fail_code = ST_TRUNC;
            end
          end else begin
            fail      = 1'b1;
            fail_code = ST_UNKNOWN;
          end
        end
      end
      PH_IDLEN: begin
        idlen_nxt = b;
        phase_nxt = PH_AULEN;
        if (last) begin
          fail      = 1'b1;
          fail_code = ST_TRUNC;
        end
      end
      PH_AULEN: begin
        if (len_sum == '0) begin
          cntdn_nxt = NONCE_BYTES;
          nonce_nxt = '0;
          phase_nxt = PH_NONCE;
        end else begin
          cntdn_nxt = len_sum;
          phase_nxt = PH_SKIP;
        end
        if (last) begin
          fail      = 1'b1;
          fail_code = ST_TRUNC;
        end
      end
      PH_SKIP: begin
        cntdn_nxt = cntdn_dec;
        if (cntdn_dec == '0) begin
          cntdn_nxt = NONCE_BYTES;
          nonce_nxt = '0;
          phase_nxt = PH_NONCE;
        end
        if (last) begin
          fail      = 1'b1;
          fail_code = ST_TRUNC;
        end
      end
      PH_NONCE: begin
        nonce_nxt = {nonce_r[CAP_W-BYTE_W-1:0], b};
        cntdn_nxt = cntdn_dec;
        if (cntdn_dec == '0) begin
          nonce_seen_nxt = 1'b1;
          phase_nxt      = PH_CONFIRM;
        end
        if (last) begin
          fail      = 1'b1;
          fail_code = ST_TRUNC;
        end
      end
      PH_CONFIRM: begin
        if (b != '0) begin
          fail      = 1'b1;
          fail_code = ST_BADCONF;
        end else begin
          phase_nxt = PH_HEAD;
        end
      end
      PH_ORIGIN: begin
        origin_nxt = {origin_r[CAP_W-BYTE_W-1:0], b};
        cntdn_nxt  = cntdn_dec;
        if (cntdn_dec == '0) begin
          origin_seen_nxt = 1'b1;
          phase_nxt       = PH_HEAD;
        end else if (last) begin
          fail      = 1'b1;
          fail_code = ST_TRUNC;
        end
      end
      PH_PAYLOAD: ;
      default:    phase_nxt = PH_DROP;
    endcase

    if (emit_payload) pcnt_nxt = pcnt_r + 1'b1;

    // First error sticks; any error drops the rest of the datagram
    err_nxt = err_r;
    if (fail) begin
      phase_nxt = PH_DROP;
      if (err_r == ST_OK) err_nxt = fail_code;
    end
  end

  // Result beats for the accepted byte
  always_comb begin
    unique case (eff_phase)
      PH_HEAD:    emit_payload = !held_zero_r && !(b == '0 && !last);
      PH_PAYLOAD: emit_payload = 1'b1;
      default:    emit_payload = 1'b0;
    endcase

    pay_beat                = '0;
    pay_beat.item_kind      = KIND_PAYLOAD;
    pay_beat.payload_byte   = b;
    pay_beat.last_of_run    = !last;

    sum_beat                = '0;
    sum_beat.item_kind      = KIND_SUMMARY;
    sum_beat.status         = err_nxt;
    sum_beat.nonce_present  = nonce_seen_nxt;
    sum_beat.nonce_value    = nonce_seen_nxt ? nonce_nxt : '0;
    sum_beat.origin_present = origin_seen_nxt;
    sum_beat.origin_raw     = origin_seen_nxt ? origin_nxt : '0;
    sum_beat.payload_length = LEN_W'(pcnt_nxt);
    sum_beat.last_of_run    = 1'b1;
  end

  // Parse state registers; a summary returns everything to reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HEAD;
      held_zero_r   <= 1'b0;
      cntdn_r       <= '0;
      nonce_seen_r  <= 1'b0;
      origin_seen_r <= 1'b0;
      err_r         <= ST_OK;
      pcnt_r        <= '0;
      tcnt_r        <= '0;
    end else if (accept) begin
      if (last) begin
        phase_r       <= PH_HEAD;
        held_zero_r   <= 1'b0;
        cntdn_r       <= '0;
        nonce_seen_r  <= 1'b0;
        origin_seen_r <= 1'b0;
        err_r         <= ST_OK;
        pcnt_r        <= '0;
        tcnt_r        <= '0;
      end else begin
        phase_r       <= phase_nxt;
        held_zero_r   <= held_zero_nxt;
        cntdn_r       <= cntdn_nxt;
        nonce_seen_r  <= nonce_seen_nxt;
        origin_seen_r <= origin_seen_nxt;
        err_r         <= err_nxt;
        pcnt_r        <= pcnt_nxt;
        tcnt_r        <= tcnt_nxt;
      end
    end
  end

  // Capture registers: nonce and origin reach the summary only behind their seen flags
  always_ff @(posedge clk) begin
    if (accept) begin
      idlen_r  <= idlen_nxt;
      nonce_r  <= nonce_nxt;
      origin_r <= origin_nxt;
    end
  end

  // Queue writes: payload beat first, summary after it
  logic              push0, push1;
  logic [QPTR_W-1:0] wr_ptr_p1;
  logic [QCNT_W-1:0] npush;

  assign push0     = accept && (emit_payload || last);
  assign push1     = accept && emit_payload && last;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;
  assign npush     = QCNT_W'(push0) + QCNT_W'(push1);

  always_ff @(posedge clk) begin
    if (push0) q_r[wr_ptr_r] <= emit_payload ? pay_beat : sum_beat;
    if (push1) q_r[wr_ptr_p1] <= sum_beat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      qcnt_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(npush);
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      qcnt_r <= qcnt_r + npush - QCNT_W'(pop);
    end
  end

endmodule
`default_nettype wire
